>>> hdl/nsfq_pkg.sv
// Shared types, codes and helper functions for the NMEA sentence framer queue.
// Used by the controller, the datapath, the top level and the checker.
package nsfq_pkg;

  localparam int MaxSentenceDef = 128;
  localparam int SlotsDef       = 8;

  localparam logic [6:0] PopLimit = 7'd64;

  localparam logic [7:0] ChDollar  = 8'h24;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChR       = 8'h52;
  localparam logic [7:0] ChM       = 8'h4D;
  localparam logic [7:0] ChC       = 8'h43;

  localparam int MinLineLen = 10;
  localparam int StarWindow = 7;
  localparam int FieldTime  = 1;
  localparam int FieldDate  = 9;
  localparam int FieldSat   = 10;
  localparam int DigitCount = 6;

  localparam logic [1:0] CmdFeed = 2'd0;
  localparam logic [1:0] CmdPop  = 2'd1;
  localparam logic [1:0] CmdTime = 2'd2;

  localparam logic [1:0] KindFeed   = 2'd0;
  localparam logic [1:0] KindByte   = 2'd1;
  localparam logic [1:0] KindNone   = 2'd2;
  localparam logic [1:0] KindTime   = 2'd3;

  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvAccepted = 3'd1;
  localparam logic [2:0] EvDropOld  = 3'd2;
  localparam logic [2:0] EvDropMid  = 3'd3;
  localparam logic [2:0] EvRejected = 3'd4;
  localparam logic [2:0] EvOverlong = 3'd5;

  typedef struct packed {
    logic accept;
    logic load_feed;
    logic load_none;
    logic pop_start;
    logic pop_rd;
    logic load_byte;
    logic load_time;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic pop_none;
    logic last_byte;
  } ctrl_sts_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic hex_ok(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h41) && (c <= 8'h46)) || ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] r;
    if (is_digit(c)) begin
      r = c[3:0];
    end else begin
      r = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic logic [6:0] pair10(input logic [3:0] a, input logic [3:0] b);
    return ({3'b000, a} * 7'd10) + {3'b000, b};
  endfunction

endpackage

>>> hdl/nsfq_ctrl.sv
// Controller state machine of the NMEA sentence framer queue.
// Depends on nsfq_pkg for the command and status structs and the command codes.
module nsfq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         cmd_i,
  output logic               in_ready_o,
  input  nsfq_pkg::ctrl_sts_t sts_i,
  output nsfq_pkg::ctrl_cmd_t cmd_o
);
  import nsfq_pkg::*;

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SFeed   = 3'd1;
  localparam logic [2:0] SPopSet = 3'd2;
  localparam logic [2:0] SPopRd  = 3'd3;
  localparam logic [2:0] SPopOut = 3'd4;
  localparam logic [2:0] STime   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          case (cmd_i)
            CmdPop:  state_d = SPopSet;
            CmdTime: state_d = STime;
            default: state_d = SFeed;
          endcase
        end
      end
      SFeed: begin
        if (sts_i.out_free) begin
          cmd_o.load_feed = 1'b1;
          state_d         = SIdle;
        end
      end
      SPopSet: begin
        if (sts_i.pop_none) begin
          if (sts_i.out_free) begin
            cmd_o.load_none = 1'b1;
            state_d         = SIdle;
          end
        end else begin
          cmd_o.pop_start = 1'b1;
          state_d         = SPopRd;
        end
      end
      SPopRd: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = SPopOut;
      end
      SPopOut: begin
        if (sts_i.out_free) begin
          cmd_o.load_byte = 1'b1;
          state_d         = sts_i.last_byte ? SIdle : SPopRd;
        end
      end
      STime: begin
        if (sts_i.out_free) begin
          cmd_o.load_time = 1'b1;
          state_d         = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hdl/nsfq_dp.sv
// Datapath of the NMEA sentence framer queue: line tracking, slot memory,
// ring pointers, time latch and output register. Depends on nsfq_pkg.
module nsfq_dp #(
  parameter int MAX_SENTENCE = nsfq_pkg::MaxSentenceDef,
  parameter int SLOTS        = nsfq_pkg::SlotsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nsfq_pkg::ctrl_cmd_t cmd_i,
  output nsfq_pkg::ctrl_sts_t sts_o,
  input  logic [1:0]          in_cmd_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [6:0]          pop_max_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic [2:0]          event_res_o,
  output logic                pending_o,
  output logic [7:0]          out_byte_o,
  output logic                last_o,
  output logic [4:0]          hour_o,
  output logic [5:0]          minute_o,
  output logic [5:0]          second_o,
  output logic [4:0]          day_o,
  output logic [3:0]          month_o,
  output logic [6:0]          year_o,
  output logic                time_valid_o
);
  import nsfq_pkg::*;

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int OW    = $clog2(MAX_SENTENCE);
  localparam int LW    = $clog2(MAX_SENTENCE + 1);
  localparam int AW    = SW + OW;
  localparam int DEPTH = 2 ** AW;
  localparam int CW    = (LW > 7) ? LW : 7;

  localparam logic [LW-1:0] MaxLen   = LW'(MAX_SENTENCE);
  localparam logic [SW-1:0] SlotLast = SW'(SLOTS - 1);

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SlotLast) ? '0 : (s + SW'(1));
  endfunction

  logic [7:0] mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd, rdata_q;

  logic [LW-1:0] len_q, len_d;
  logic          inside_q, inside_d;
  logic          nl_q, nl_d;
  logic [2:0]    ev_q, ev_d;
  logic [7:0]    xor_q, xor_d, xstar_q, xstar_d, hi_q, hi_d, lo_q, lo_d;
  logic [LW-1:0] star_q, star_d;
  logic          star_seen_q, star_seen_d;
  logic [3:0]    fld_q, fld_d;
  logic [2:0]    flen_q, flen_d;
  logic          fok_q, fok_d, t_ok_q, t_ok_d, d_ok_q, d_ok_d, rmc_q, rmc_d;
  logic [3:0]    tdig_q [DigitCount];
  logic [3:0]    tdig_d [DigitCount];
  logic [3:0]    ddig_q [DigitCount];
  logic [3:0]    ddig_d [DigitCount];

  logic [LW-1:0] slen_q [SLOTS];
  logic          slen_we;
  logic [SW-1:0] ws_q, ws_d, rs_q, rs_d;
  logic [LW-1:0] ro_q, ro_d;
  logic [6:0]    pm_q, pm_d, cnt_q, cnt_d;

  logic [4:0] th_q, th_d;
  logic [5:0] tm_q, tm_d, ts_q, ts_d;
  logic [4:0] td_q, td_d;
  logic [3:0] tmo_q, tmo_d;
  logic [6:0] ty_q, ty_d;
  logic       fresh_q, fresh_d;

  logic       ov_q, ov_d;
  logic [1:0] okind_q, okind_d;
  logic [2:0] oev_q, oev_d;
  logic       opend_q, opend_d, olast_q, olast_d, otv_q, otv_d;
  logic [7:0] obyte_q, obyte_d;
  logic [4:0] oh_q, oh_d, od_q, od_d;
  logic [5:0] omi_q, omi_d, ose_q, ose_d;
  logic [3:0] omo_q, omo_d;
  logic [6:0] oy_q, oy_d;

  logic          out_free, good, tvalid, full, empty, last_byte;
  logic [SW-1:0] ws_next;
  logic [LW-1:0] slen, avail;
  logic [CW-1:0] n_pop;
  logic [6:0]    hr, mi, se, dy, mo, yr;

  assign out_free = !ov_q || out_ready_i;

  always_comb begin
    good = (len_q >= LW'(MinLineLen)) && star_seen_q && (star_q != '0) &&
           (({1'b0, star_q} + (LW+1)'(StarWindow)) >= {1'b0, len_q}) &&
           (({1'b0, star_q} + (LW+1)'(2)) < {1'b0, len_q}) &&
           hex_ok(hi_q) && hex_ok(lo_q) && (xstar_q == {hex_val(hi_q), hex_val(lo_q)});
    hr = pair10(tdig_q[0], tdig_q[1]);
    mi = pair10(tdig_q[2], tdig_q[3]);
    se = pair10(tdig_q[4], tdig_q[5]);
    dy = pair10(ddig_q[0], ddig_q[1]);
    mo = pair10(ddig_q[2], ddig_q[3]);
    yr = pair10(ddig_q[4], ddig_q[5]);
    tvalid = rmc_q && t_ok_q && d_ok_q && (hr <= 7'd23) && (mi <= 7'd59) && (se <= 7'd59) &&
             (mo >= 7'd1) && (mo <= 7'd12) && (dy >= 7'd1) && (dy <= 7'd31);
  end

  always_comb begin
    ws_next   = slot_inc(ws_q);
    full      = (ws_next == rs_q);
    empty     = (rs_q == ws_q);
    slen      = slen_q[rs_q];
    avail     = (ro_q < slen) ? (slen - ro_q) : '0;
    n_pop     = (CW'(avail) > CW'(pm_q)) ? CW'(pm_q) : CW'(avail);
    last_byte = (cnt_q == 7'd1);
  end

  assign sts_o.out_free  = out_free;
  assign sts_o.pop_none  = empty || (pm_q == '0) || (avail == '0);
  assign sts_o.last_byte = last_byte;

  always_comb begin
    len_d = len_q; inside_d = inside_q; nl_d = nl_q; ev_d = ev_q;
    xor_d = xor_q; xstar_d = xstar_q; hi_d = hi_q; lo_d = lo_q;
    star_d = star_q; star_seen_d = star_seen_q; fld_d = fld_q; flen_d = flen_q;
    fok_d = fok_q; t_ok_d = t_ok_q; d_ok_d = d_ok_q; rmc_d = rmc_q;
    tdig_d = tdig_q; ddig_d = ddig_q;
    ws_d = ws_q; rs_d = rs_q; ro_d = ro_q; pm_d = pm_q; cnt_d = cnt_q;
    th_d = th_q; tm_d = tm_q; ts_d = ts_q; td_d = td_q; tmo_d = tmo_q; ty_d = ty_q;
    fresh_d = fresh_q;
    mem_we = 1'b0; mem_wa = {ws_q, len_q[OW-1:0]}; mem_wd = rx_byte_i;
    mem_re = 1'b0; mem_ra = {rs_q, ro_q[OW-1:0]};
    slen_we = 1'b0;
    ov_d = ov_q && !out_ready_i;
    okind_d = okind_q; oev_d = oev_q; opend_d = opend_q; olast_d = olast_q; otv_d = otv_q;
    obyte_d = obyte_q; oh_d = oh_q; od_d = od_q; omi_d = omi_q; ose_d = ose_q;
    omo_d = omo_q; oy_d = oy_q;

    if (cmd_i.accept) begin
      case (in_cmd_i)
        CmdFeed: begin
          ev_d = EvNone;
          nl_d = 1'b0;
          if (rx_byte_i == ChDollar) begin
            mem_we = 1'b1;
            mem_wa = {ws_q, {OW{1'b0}}};
            len_d = LW'(1); inside_d = 1'b1; xor_d = '0; star_seen_d = 1'b0;
            star_d = '0; fld_d = '0; flen_d = '0; fok_d = 1'b1;
            t_ok_d = 1'b0; d_ok_d = 1'b0; rmc_d = 1'b1;
          end else if (inside_q) begin
            if (len_q >= MaxLen) begin
              inside_d = 1'b0;
              ev_d     = EvOverlong;
            end else begin
              mem_we = 1'b1;
              len_d  = len_q + LW'(1);
              xor_d  = xor_q ^ rx_byte_i;
              if (star_seen_q && (len_q == star_q + LW'(1))) hi_d = rx_byte_i;
              if (star_seen_q && (len_q == star_q + LW'(2))) lo_d = rx_byte_i;
              if (rx_byte_i == ChStar) begin
                star_d = len_q; star_seen_d = 1'b1; xstar_d = xor_q;
              end
              if ((rx_byte_i == ChComma) || (rx_byte_i == ChStar)) begin
                if (fld_q == 4'(FieldTime)) t_ok_d = (flen_q == 3'(DigitCount)) && fok_q;
                if (fld_q == 4'(FieldDate)) d_ok_d = (flen_q == 3'(DigitCount)) && fok_q;
                if (fld_q != 4'(FieldSat)) fld_d = fld_q + 4'd1;
                flen_d = '0;
                fok_d  = 1'b1;
              end else if (flen_q != 3'(DigitCount)) begin
                fok_d = fok_q && is_digit(rx_byte_i);
                if (fld_q == 4'(FieldTime)) tdig_d[flen_q] = rx_byte_i[3:0];
                if (fld_q == 4'(FieldDate)) ddig_d[flen_q] = rx_byte_i[3:0];
                flen_d = flen_q + 3'd1;
              end
              if ((len_q == LW'(3)) && (rx_byte_i != ChR)) rmc_d = 1'b0;
              if ((len_q == LW'(4)) && (rx_byte_i != ChM)) rmc_d = 1'b0;
              if ((len_q == LW'(5)) && (rx_byte_i != ChC)) rmc_d = 1'b0;
              if (rx_byte_i == ChNewline) begin
                nl_d     = 1'b1;
                inside_d = 1'b0;
              end
            end
          end
        end
        CmdPop: pm_d = (pop_max_i > PopLimit) ? PopLimit : pop_max_i;
        CmdTime: ;
        default: begin
          ev_d = EvNone;
          nl_d = 1'b0;
        end
      endcase
    end

    if (cmd_i.pop_start) cnt_d = 7'(n_pop);
    if (cmd_i.pop_rd) mem_re = 1'b1;

    if (cmd_i.load_feed || cmd_i.load_none || cmd_i.load_byte || cmd_i.load_time) begin
      ov_d = 1'b1; oev_d = EvNone; obyte_d = '0; olast_d = 1'b1; otv_d = 1'b0;
      oh_d = '0; omi_d = '0; ose_d = '0; od_d = '0; omo_d = '0; oy_d = '0;
    end

    if (cmd_i.load_feed) begin
      okind_d = KindFeed;
      oev_d   = ev_q;
      if (nl_q) begin
        if (good) begin
          slen_we = 1'b1;
          ws_d    = ws_next;
          oev_d   = EvAccepted;
          if (full) begin
            oev_d = (ro_q != '0) ? EvDropMid : EvDropOld;
            rs_d  = slot_inc(rs_q);
            ro_d  = '0;
          end
          if (tvalid) begin
            th_d = hr[4:0]; tm_d = mi[5:0]; ts_d = se[5:0];
            td_d = dy[4:0]; tmo_d = mo[3:0]; ty_d = yr;
            fresh_d = 1'b1;
          end
        end else begin
          oev_d = EvRejected;
        end
      end
    end

    if (cmd_i.load_none) begin
      okind_d = KindNone;
      if (!empty && (pm_q != '0)) begin
        ro_d = '0;
        rs_d = slot_inc(rs_q);
      end
    end

    if (cmd_i.load_byte) begin
      okind_d = KindByte;
      obyte_d = rdata_q;
      olast_d = last_byte;
      ro_d    = ro_q + LW'(1);
      cnt_d   = cnt_q - 7'd1;
      if (last_byte && ((ro_q + LW'(1)) >= slen)) begin
        ro_d = '0;
        rs_d = slot_inc(rs_q);
      end
    end

    if (cmd_i.load_time) begin
      okind_d = KindTime;
      if (fresh_q) begin
        oh_d = th_q; omi_d = tm_q; ose_d = ts_q; od_d = td_q; omo_d = tmo_q; oy_d = ty_q;
        otv_d = 1'b1;
        fresh_d = 1'b0;
      end
    end

    if (cmd_i.load_feed || cmd_i.load_none || cmd_i.load_byte || cmd_i.load_time) begin
      opend_d = (rs_d != ws_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata_q <= mem[mem_ra];
    if (slen_we) slen_q[ws_q] <= len_q;
  end

  always_ff @(posedge clk_i) begin
    xor_d_hold: begin
      xor_q <= xor_d; xstar_q <= xstar_d; hi_q <= hi_d; lo_q <= lo_d;
      star_q <= star_d; star_seen_q <= star_seen_d; fld_q <= fld_d; flen_q <= flen_d;
      fok_q <= fok_d; t_ok_q <= t_ok_d; d_ok_q <= d_ok_d; rmc_q <= rmc_d;
      tdig_q <= tdig_d; ddig_q <= ddig_d; pm_q <= pm_d; cnt_q <= cnt_d;
      okind_q <= okind_d; oev_q <= oev_d; opend_q <= opend_d; olast_q <= olast_d;
      otv_q <= otv_d; obyte_q <= obyte_d; oh_q <= oh_d; od_q <= od_d;
      omi_q <= omi_d; ose_q <= ose_d; omo_q <= omo_d; oy_q <= oy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; inside_q <= 1'b0; nl_q <= 1'b0; ev_q <= EvNone;
      ws_q <= '0; rs_q <= '0; ro_q <= '0;
      th_q <= '0; tm_q <= '0; ts_q <= '0; td_q <= '0; tmo_q <= '0; ty_q <= '0;
      fresh_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      len_q <= len_d; inside_q <= inside_d; nl_q <= nl_d; ev_q <= ev_d;
      ws_q <= ws_d; rs_q <= rs_d; ro_q <= ro_d;
      th_q <= th_d; tm_q <= tm_d; ts_q <= ts_d; td_q <= td_d; tmo_q <= tmo_d; ty_q <= ty_d;
      fresh_q <= fresh_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o  = ov_q;
  assign kind_o       = okind_q;
  assign event_res_o  = oev_q;
  assign pending_o    = opend_q;
  assign out_byte_o   = obyte_q;
  assign last_o       = olast_q;
  assign hour_o       = oh_q;
  assign minute_o     = omi_q;
  assign second_o     = ose_q;
  assign day_o        = od_q;
  assign month_o      = omo_q;
  assign year_o       = oy_q;
  assign time_valid_o = otv_q;

endmodule

>>> hdl/nmea_sentence_framer_queue.sv
// NMEA sentence framer queue: a feed byte goes through a feed state to its status transfer,
// a pop through a setup state, then a read and an output state per returned byte (one slot
// memory read each), a time request through a time state; one command is in flight at a time.
// The output register lets a new command be taken while a result waits.
// Reset (asynchronous, active low) empties the ring and clears line and time state.
module nmea_sentence_framer_queue #(
  parameter int MAX_SENTENCE = nsfq_pkg::MaxSentenceDef,
  parameter int SLOTS        = nsfq_pkg::SlotsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] rx_byte_i,
  input  logic [6:0] pop_max_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [2:0] event_res_o,
  output logic       pending_o,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic [4:0] hour_o,
  output logic [5:0] minute_o,
  output logic [5:0] second_o,
  output logic [4:0] day_o,
  output logic [3:0] month_o,
  output logic [6:0] year_o,
  output logic       time_valid_o
);
  import nsfq_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  ctrl_sts_t ctrl_sts;

  nsfq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .in_ready_o (in_ready_o),
    .sts_i      (ctrl_sts),
    .cmd_o      (ctrl_cmd)
  );

  nsfq_dp #(
    .MAX_SENTENCE (MAX_SENTENCE),
    .SLOTS        (SLOTS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (ctrl_cmd),
    .sts_o        (ctrl_sts),
    .in_cmd_i     (cmd_i),
    .rx_byte_i    (rx_byte_i),
    .pop_max_i    (pop_max_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .event_res_o  (event_res_o),
    .pending_o    (pending_o),
    .out_byte_o   (out_byte_o),
    .last_o       (last_o),
    .hour_o       (hour_o),
    .minute_o     (minute_o),
    .second_o     (second_o),
    .day_o        (day_o),
    .month_o      (month_o),
    .year_o       (year_o),
    .time_valid_o (time_valid_o)
  );

endmodule

>>> hdl/nsfq_checker.sv
// Port-level assertions for the NMEA sentence framer queue, bound to the top level.
// Depends on nsfq_pkg for the result kind and event codes.
module nsfq_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] kind_o,
  input logic [2:0] event_res_o,
  input logic [7:0] out_byte_o,
  input logic [4:0] hour_o,
  input logic [3:0] month_o,
  input logic       time_valid_o
);
  import nsfq_pkg::*;

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("A second command was taken while one was in flight.");

  a_event_feed_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KindFeed)) |-> (event_res_o == EvNone))
    else $error("An event code appeared on a result that is not a feed status.");

  a_byte_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KindByte)) |-> (out_byte_o == 8'h00))
    else $error("A data byte appeared on a result that is not a popped byte.");

  a_stale_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !time_valid_o) |-> ((hour_o == 5'd0) && (month_o == 4'd0)))
    else $error("Time fields were nonzero without fresh time.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_byte_o)))
    else $error("A stalled result transfer changed or was withdrawn.");

endmodule

bind nmea_sentence_framer_queue nsfq_checker u_nsfq_checker (.*);
